[hdl/bmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared widths, command and status codes, sequencer states and the search
// summary that the scan unit hands to the top level.
// ----------------------------------------------------------------------------
package bmt_pkg;

   localparam int KEY_W    = 48;
   localparam int CB_W     = 10;
   localparam int CAP_W    = 11;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 3;
   localparam int REC_W    = 64;

   // stored word: {valid, key, cblock, recency}
   localparam int WORD_W = 1 + KEY_W + CB_W + REC_W;

   localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_ANY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RENAME     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic             hit;
      logic [CB_W-1:0]  hit_cb;
      logic             free_found;
      logic             best_found;
      logic [KEY_W-1:0] best_key;
      logic [CB_W-1:0]  best_cb;
   } search_type;

endpackage

[hdl/bmt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt interfaces
// Command, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [bmt_pkg::KIND_W-1:0]    kind;
   logic [bmt_pkg::KEY_W-1:0]     key;
   logic [bmt_pkg::KEY_W-1:0]     old_key;
   logic [bmt_pkg::CB_W-1:0]      cblock_in;
   modport source (output valid, kind, key, old_key, cblock_in, input ready);
   modport sink   (input valid, kind, key, old_key, cblock_in, output ready);
endinterface

interface bmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmt_pkg::STATUS_W-1:0]  status;
   logic [bmt_pkg::CB_W-1:0]      cblock_out;
   logic [bmt_pkg::KEY_W-1:0]     popped_key;
   logic [bmt_pkg::CAP_W-1:0]     occupancy;
   modport source (output valid, status, cblock_out, popped_key, occupancy, input ready);
   modport sink   (input valid, status, cblock_out, popped_key, occupancy, output ready);
endinterface

interface bmt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bmt_pkg::CAP_W-1:0]     data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/bmt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/bmt_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_scan
// Search unit: takes one read-back word a cycle and keeps the first key
// match, the first free slot and the newest valid entry.
// ----------------------------------------------------------------------------
module bmt_scan #(
   parameter int AW = 10
) (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        rd_valid,
   input  logic [AW-1:0]               rd_idx,
   input  logic [bmt_pkg::WORD_W-1:0]  rd_word,
   input  logic [bmt_pkg::KEY_W-1:0]   match_key,
   output bmt_pkg::search_type         result,
   output logic [AW-1:0]               hit_idx,
   output logic [AW-1:0]               free_idx,
   output logic [AW-1:0]               best_idx
);

   bmt_pkg::search_type             res_ff, res_in;
   logic [AW-1:0]                   hit_idx_ff, hit_idx_in;
   logic [AW-1:0]                   free_idx_ff, free_idx_in;
   logic [AW-1:0]                   best_idx_ff, best_idx_in;
   logic [bmt_pkg::REC_W-1:0]       best_rec_ff, best_rec_in;

   logic                            w_valid;
   logic [bmt_pkg::KEY_W-1:0]       w_key;
   logic [bmt_pkg::CB_W-1:0]        w_cb;
   logic [bmt_pkg::REC_W-1:0]       w_rec;

   assign {w_valid, w_key, w_cb, w_rec} = rd_word;

   always_comb begin
      res_in      = res_ff;
      hit_idx_in  = hit_idx_ff;
      free_idx_in = free_idx_ff;
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      if (start) begin
         res_in.hit        = 1'b0;
         res_in.free_found = 1'b0;
         res_in.best_found = 1'b0;
      end else if (rd_valid) begin
         if (w_valid && w_key == match_key && !res_ff.hit) begin
            res_in.hit    = 1'b1;
            res_in.hit_cb = w_cb;
            hit_idx_in    = rd_idx;
         end
         if (!w_valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            free_idx_in       = rd_idx;
         end
         // strict compare: on equal stamps the lower index stays
         if (w_valid && (!res_ff.best_found || w_rec > best_rec_ff)) begin
            res_in.best_found = 1'b1;
            res_in.best_key   = w_key;
            res_in.best_cb    = w_cb;
            best_idx_in       = rd_idx;
            best_rec_in       = w_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
   end

   assign result   = res_ff;
   assign hit_idx  = hit_idx_ff;
   assign free_idx = free_idx_ff;
   assign best_idx = best_idx_ff;

endmodule

[hdl/block_map_table_lifo_evict.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_map_table_lifo_evict
// Key to cache-block mapping table with newest-first eviction, held in one
// single-port RAM and searched by a full sweep per command.
// ----------------------------------------------------------------------------
// Operation: each command sweeps every entry through the single RAM read
//   port (one entry a cycle), then writes back and registers the result. No
//   new command is taken until the last one leaves write-back, which waits for a free result register.
// Reset: synchronous; a clearing pass then writes every entry invalid, and no
//   command is taken until it ends. Capacity resets to 1024, recency stamp and
//   occupancy to zero.
// ----------------------------------------------------------------------------
module block_map_table_lifo_evict #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   bmt_req_if.sink    req_port,
   bmt_rsp_if.source  rsp_port,
   bmt_csr_if.sink    csr_port
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

   // sequencer
   bmt_pkg::state_type state_ff, state_in;

   // command register, loaded on accept
   logic [bmt_pkg::KIND_W-1:0] kind_ff;
   logic [bmt_pkg::KEY_W-1:0]  key_ff;
   logic [bmt_pkg::KEY_W-1:0]  old_key_ff;
   logic [bmt_pkg::CB_W-1:0]   cb_ff;

   // scalar state
   logic [bmt_pkg::CAP_W-1:0]  cap_ff;
   logic [bmt_pkg::REC_W-1:0]  rec_ff, rec_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   // sweep counters: clear pass and search issue
   logic [AW-1:0]              clr_ff;
   logic [AW:0]                issue_ff;
   logic                       rd_valid_ff;
   logic [AW-1:0]              rd_idx_ff;

   // result register parts the two sides
   logic                          rsp_valid_ff;
   logic [bmt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bmt_pkg::CB_W-1:0]      rsp_cb_ff, rsp_cb_in;
   logic [bmt_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [bmt_pkg::CAP_W-1:0]     rsp_occ_ff, rsp_occ_in;

   // RAM port
   logic                        mem_we;
   logic [AW-1:0]               mem_addr;
   logic [bmt_pkg::WORD_W-1:0]  mem_wdata;
   logic [bmt_pkg::WORD_W-1:0]  mem_rdata;

   // search summary
   bmt_pkg::search_type         srch;
   logic [AW-1:0]               hit_idx, free_idx, best_idx;

   logic                        req_acc;
   logic                        issue;
   logic                        scan_done;
   logic                        out_free;
   logic                        finish;
   logic                        full;
   logic [31:0]                 limit;
   logic [31:0]                 count_ext;
   logic [bmt_pkg::KEY_W-1:0]   match_key;

   assign req_acc   = req_port.valid && req_port.ready;
   assign issue     = (state_ff == bmt_pkg::ST_SCAN) && (issue_ff < (AW+1)'(TABLE_DEPTH));
   assign scan_done = rd_valid_ff && (rd_idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign finish    = (state_ff == bmt_pkg::ST_WRITE) && out_free;
   assign match_key = (kind_ff == bmt_pkg::KIND_RENAME) ? old_key_ff : key_ff;

   // effective limit is the smaller of the register and the built depth
   assign limit = (32'(cap_ff) < 32'(TABLE_DEPTH)) ? 32'(cap_ff) : 32'(TABLE_DEPTH);
   assign full  = 32'(count_ff) >= limit;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmt_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = bmt_pkg::ST_IDLE;
            end
         end
         bmt_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = bmt_pkg::ST_SCAN;
            end
         end
         bmt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = bmt_pkg::ST_WRITE;
            end
         end
         bmt_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = bmt_pkg::ST_IDLE;
            end
         end
         default: state_in = bmt_pkg::ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   // Write-back: at most one RAM write per command, then the result word; the clearing pass writes each entry invalid.
   always_comb begin
      mem_we        = 1'b0;
      mem_addr      = issue_ff[AW-1:0];
      mem_wdata     = '0;
      rec_in        = rec_ff;
      count_in      = count_ff;
      rsp_status_in = bmt_pkg::STATUS_OK;
      rsp_cb_in     = '0;
      rsp_key_in    = '0;
      case (state_ff)
         bmt_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         bmt_pkg::ST_WRITE: begin
            case (kind_ff)
               bmt_pkg::KIND_LOOKUP: begin
                  if (srch.hit) begin
                     rsp_cb_in = srch.hit_cb;
                  end else begin
                     rsp_status_in = bmt_pkg::STATUS_MISS;
                  end
               end
               bmt_pkg::KIND_LOAD: begin
                  if (full) begin
                     rsp_status_in = bmt_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = finish;
                     mem_addr  = free_idx;
                     mem_wdata = {1'b1, key_ff, cb_ff, rec_ff};
                     rec_in    = rec_ff + 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end
               bmt_pkg::KIND_REMOVE: begin
                  if (srch.hit) begin
                     mem_we   = finish;
                     mem_addr = hit_idx;
                     count_in = count_ff - 1'b1;
                  end else begin
                     rsp_status_in = bmt_pkg::STATUS_NOT_FOUND;
                  end
               end
               bmt_pkg::KIND_REMOVE_ANY: begin
                  if (srch.best_found) begin
                     mem_we     = finish;
                     mem_addr   = best_idx;
                     count_in   = count_ff - 1'b1;
                     rsp_cb_in  = srch.best_cb;
                     rsp_key_in = srch.best_key;
                  end else begin
                     rsp_status_in = bmt_pkg::STATUS_NOT_FOUND;
                  end
               end
               bmt_pkg::KIND_RENAME: begin
                  if (srch.hit) begin
                     mem_we    = finish;
                     mem_addr  = hit_idx;
                     mem_wdata = {1'b1, key_ff, srch.hit_cb, rec_ff};
                     rec_in    = rec_ff + 1'b1;
                  end else begin
                     rsp_status_in = bmt_pkg::STATUS_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign count_ext  = 32'(count_in);
   assign rsp_occ_in = count_ext[bmt_pkg::CAP_W-1:0];

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmt_pkg::ST_CLEAR;
         cap_ff       <= bmt_pkg::CAP_RESET;
         rec_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         if (csr_port.valid) begin
            cap_ff <= csr_port.data;
         end
         if (state_ff == bmt_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (req_acc) begin
            issue_ff <= '0;
         end else if (issue) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (finish) begin
            rec_ff       <= rec_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rd_idx_ff <= issue_ff[AW-1:0];
      if (req_acc) begin
         kind_ff    <= req_port.kind;
         key_ff     <= req_port.key;
         old_key_ff <= req_port.old_key;
         cb_ff      <= req_port.cblock_in;
      end
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_cb_ff     <= rsp_cb_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign req_port.ready      = (state_ff == bmt_pkg::ST_IDLE);
   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_status_ff;
   assign rsp_port.cblock_out = rsp_cb_ff;
   assign rsp_port.popped_key = rsp_key_ff;
   assign rsp_port.occupancy  = rsp_occ_ff;

   // ---------------------------------------------------------------- datapath
   bmt_ram #(
      .WIDTH (bmt_pkg::WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   bmt_scan #(
      .AW (AW)
   ) u_scan (
      .clock     (clock),
      .start     (req_acc),
      .rd_valid  (rd_valid_ff),
      .rd_idx    (rd_idx_ff),
      .rd_word   (mem_rdata),
      .match_key (match_key),
      .result    (srch),
      .hit_idx   (hit_idx),
      .free_idx  (free_idx),
      .best_idx  (best_idx)
   );

   // ---------------------------------------------------------------- checks
   // occupancy never passes the built depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_DEPTH))
      else $error("occupancy above table depth");

   // a load that is not refused must have found a free slot
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmt_pkg::ST_WRITE && kind_ff == bmt_pkg::KIND_LOAD && !full)
      |-> srch.free_found)
      else $error("load with no free slot");

   // a hit on remove implies at least one mapping is counted
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmt_pkg::ST_WRITE && srch.hit && kind_ff == bmt_pkg::KIND_REMOVE)
      |-> (count_ff != '0))
      else $error("remove hit with zero occupancy");

   // the RAM sweep only issues reads while searching
   a_issue_state: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff) == bmt_pkg::ST_SCAN)
      else $error("read issued outside search");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the mapping table with newest-first eviction. Every command word
// (lookup, load, remove, remove_any, rename) goes through a behavioural copy
// of the table. That copy gives the expected result word, and each result
// the block returns is compared with it field by field. The capacity
// register is changed between phases while the block is idle. The sender
// and the receiver idle at random, in several mixes.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH     = 1024;
   localparam int MAX_CYCLE = 3000000;

   logic clock;
   logic reset;

   bmt_req_if req_if ();
   bmt_rsp_if rsp_if ();
   bmt_csr_if csr_if ();

   block_map_table_lifo_evict #(.TABLE_DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if.sink),
      .rsp_port(rsp_if.source),
      .csr_port(csr_if.sink)
   );

   typedef struct packed {
      logic [bmt_pkg::STATUS_W-1:0] status;
      logic [bmt_pkg::CB_W-1:0]     cblock;
      logic [bmt_pkg::KEY_W-1:0]    popped;
      logic [bmt_pkg::CAP_W-1:0]    occupancy;
   } result_word_type;

   // behavioural copy of the table
   logic                      tbl_valid   [DEPTH];
   logic [bmt_pkg::KEY_W-1:0] tbl_key     [DEPTH];
   logic [bmt_pkg::CB_W-1:0]  tbl_cblock  [DEPTH];
   logic [bmt_pkg::REC_W-1:0] tbl_stamp   [DEPTH];
   logic [bmt_pkg::REC_W-1:0] stamp_next;
   int unsigned               tbl_count;
   logic [bmt_pkg::CAP_W-1:0] capacity;

   result_word_type expected_words[$];
   logic [bmt_pkg::KEY_W-1:0] live_keys[$];   // keys likely present, to aim hits at

   int  mismatches;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_stall_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLE) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
   endtask

   function automatic int lowest_match(input logic [bmt_pkg::KEY_W-1:0] k);
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   // work out the result word for one command and update the copy
   function automatic result_word_type table_predict(
         input logic [bmt_pkg::KIND_W-1:0] kind,
         input logic [bmt_pkg::KEY_W-1:0] k, input logic [bmt_pkg::KEY_W-1:0] ok,
         input logic [bmt_pkg::CB_W-1:0] cb);
      result_word_type r;
      int s;
      int unsigned lim;
      r   = '0;
      lim = (32'(capacity) < DEPTH) ? 32'(capacity) : DEPTH;
      s   = -1;
      case (kind)
         bmt_pkg::KIND_LOOKUP: begin
            s = lowest_match(k);
            if (s < 0) r.status = bmt_pkg::STATUS_MISS;
            else r.cblock = tbl_cblock[s];
         end
         bmt_pkg::KIND_LOAD: begin
            if (tbl_count < lim)
               for (int i = 0; i < DEPTH; i++)
                  if (!tbl_valid[i]) begin
                     s = i;
                     break;
                  end
            if (s < 0) r.status = bmt_pkg::STATUS_FULL;
            else begin
               tbl_valid[s]  = 1'b1;
               tbl_key[s]    = k;
               tbl_cblock[s] = cb;
               tbl_stamp[s]  = stamp_next;
               stamp_next++;
               tbl_count++;
            end
         end
         bmt_pkg::KIND_REMOVE: begin
            s = lowest_match(k);
            if (s < 0) r.status = bmt_pkg::STATUS_NOT_FOUND;
            else begin
               tbl_valid[s] = 1'b0;
               if (tbl_count > 0) tbl_count--;
            end
         end
         bmt_pkg::KIND_REMOVE_ANY: begin
            for (int i = 0; i < DEPTH; i++)
               if (tbl_valid[i] && (s < 0 || tbl_stamp[i] > tbl_stamp[s])) s = i;
            if (s < 0) r.status = bmt_pkg::STATUS_NOT_FOUND;
            else begin
               r.popped     = tbl_key[s];
               r.cblock     = tbl_cblock[s];
               tbl_valid[s] = 1'b0;
               if (tbl_count > 0) tbl_count--;
            end
         end
         bmt_pkg::KIND_RENAME: begin
            s = lowest_match(ok);
            if (s < 0) r.status = bmt_pkg::STATUS_NOT_FOUND;
            else begin
               tbl_key[s]   = k;
               tbl_stamp[s] = stamp_next;
               stamp_next++;
            end
         end
         default: ;
      endcase
      r.occupancy = tbl_count[bmt_pkg::CAP_W-1:0];
      return r;
   endfunction

   // result checker; ready changes on the falling edge
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0)
            report_mismatch("unexpected word", 64'(rsp_if.status), 64'd0);
         else begin
            want = expected_words.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
            if (rsp_if.cblock_out !== want.cblock)
               report_mismatch("cblock_out", 64'(rsp_if.cblock_out), 64'(want.cblock));
            if (rsp_if.popped_key !== want.popped)
               report_mismatch("popped_key", 64'(rsp_if.popped_key), 64'(want.popped));
            if (rsp_if.occupancy !== want.occupancy)
               report_mismatch("occupancy", 64'(rsp_if.occupancy), 64'(want.occupancy));
         end
      end
   end

   // send one command word; the prediction is made at acceptance.
   // valid stays up into the next word unless the sender idles.
   task automatic send_command(input logic [bmt_pkg::KIND_W-1:0] kind,
         input logic [bmt_pkg::KEY_W-1:0] k, input logic [bmt_pkg::KEY_W-1:0] ok,
         input logic [bmt_pkg::CB_W-1:0] cb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.kind      <= kind;
      req_if.key       <= k;
      req_if.old_key   <= ok;
      req_if.cblock_in <= cb;
      do @(posedge clock); while (!req_if.ready);
      expected_words.push_back(table_predict(kind, k, ok, cb));
      if (kind == bmt_pkg::KIND_LOAD || kind == bmt_pkg::KIND_RENAME) live_keys.push_back(k);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [bmt_pkg::CAP_W-1:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      capacity = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [bmt_pkg::KEY_W-1:0] random_key();
      return bmt_pkg::KEY_W'({$urandom, $urandom});
   endfunction

   // a key that is often present: small pool so hits and duplicates occur
   function automatic logic [bmt_pkg::KEY_W-1:0] pick_key();
      if (live_keys.size() != 0 && $urandom_range(99) < 60)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      if ($urandom_range(1)) return random_key();
      return bmt_pkg::KEY_W'($urandom_range(15));
   endfunction

   task automatic random_command(input int load_bias);
      int                           pick;
      logic [bmt_pkg::KIND_W-1:0]   kind;
      pick = $urandom_range(99);
      if (pick < load_bias)      kind = bmt_pkg::KIND_LOAD;
      else if (pick < 97)        kind = bmt_pkg::KIND_W'($urandom_range(4));
      else                       kind = bmt_pkg::KIND_W'($urandom_range(7, 5));
      send_command(kind, pick_key(), pick_key(), bmt_pkg::CB_W'($urandom));
   endtask

   // extremes of the fields, every kind, empty-table and missing-key cases
   task automatic test_directed();
      send_command(bmt_pkg::KIND_REMOVE_ANY, '0, '0, '0);                 // empty pop
      send_command(bmt_pkg::KIND_LOOKUP, '1, '0, '0);                     // miss
      send_command(bmt_pkg::KIND_REMOVE, '1, '0, '0);                     // not found
      send_command(bmt_pkg::KIND_RENAME, '0, '1, '0);                     // not found
      send_command(bmt_pkg::KIND_LOAD, '1, '0, '1);
      send_command(bmt_pkg::KIND_LOAD, '0, '1, '0);
      send_command(bmt_pkg::KIND_LOAD, '1, '0, bmt_pkg::CB_W'(10'h155));  // duplicate key
      send_command(bmt_pkg::KIND_LOOKUP, '1, '0, '0);                     // lowest index wins
      send_command(bmt_pkg::KIND_LOOKUP, '0, '0, '0);
      send_command(bmt_pkg::KIND_RENAME, 48'hAAAA_AAAA_AAAA, '0, '0);     // renamed entry becomes newest
      send_command(bmt_pkg::KIND_REMOVE_ANY, '0, '0, '0);
      send_command(bmt_pkg::KIND_REMOVE, '1, '0, '0);
      send_command(bmt_pkg::KIND_LOOKUP, '1, '0, '0);                     // duplicate now visible
      send_command(3'd5, '1, '1, '1);                                     // undefined kinds
      send_command(3'd6, '0, '0, '0);
      send_command(3'd7, 48'h5555_5555_5555, '0, '0);
      send_command(bmt_pkg::KIND_REMOVE_ANY, '0, '0, '0);
      send_command(bmt_pkg::KIND_REMOVE_ANY, '0, '0, '0);
   endtask

   // capacity at its extremes: zero refuses every load, small one fills up
   task automatic test_capacity();
      write_capacity('0);
      send_command(bmt_pkg::KIND_LOAD, 48'h1, '0, 10'h1);
      write_capacity(11'd3);
      repeat (5) send_command(bmt_pkg::KIND_LOAD, random_key(), '0, bmt_pkg::CB_W'($urandom));
      write_capacity(11'd1);     // lowered below occupancy: loads refused
      send_command(bmt_pkg::KIND_LOAD, 48'h2, '0, 10'h2);
      repeat (3) send_command(bmt_pkg::KIND_REMOVE_ANY, '0, '0, '0);
      write_capacity(11'h7FF);   // above the built depth
      send_command(bmt_pkg::KIND_LOAD, 48'h3, '0, 10'h3);
   endtask

   // random mixes under each idling pattern
   task automatic test_random(input int items, input int s_pct, input int r_pct,
                              input logic [bmt_pkg::CAP_W-1:0] cap);
      write_capacity(cap);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      for (int i = 0; i < items; i++) random_command(cap < 16 ? 50 : 35);
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = '0;
      req_if.key     = '0;
      req_if.old_key = '0;
      req_if.cblock_in = '0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      rsp_if.ready   = 1'b0;
      mismatches     = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      capacity       = bmt_pkg::CAP_RESET;
      stamp_next     = '0;
      tbl_count      = 0;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_key[i]    = '0;
         tbl_cblock[i] = '0;
         tbl_stamp[i]  = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_capacity();
      test_random(150, 0, 0, 11'd8);
      test_random(150, 51, 0, 11'd1024);
      test_random(150, 0, 51, 11'd4);
      test_random(130, 6, 6, 11'd40);

      wait_drained();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
